// File: sv/sprite_grid_scaled_blit_address_defines.svh
// Assertion macros for the sprite grid blit address generator.
`ifndef SPRITE_GRID_SCALED_BLIT_ADDRESS_DEFINES_SVH
`define SPRITE_GRID_SCALED_BLIT_ADDRESS_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define SGSBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check a condition that never holds outside reset.
`define SGSBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/sgsba_pkg.sv
package sgsba_pkg;

  localparam int unsigned PadPixels = 1;
  localparam int unsigned MaxSide   = 8192;

  // Register indexes
  localparam logic [1:0] RegAtlasW = 2'd0;
  localparam logic [1:0] RegAtlasH = 2'd1;
  localparam logic [1:0] RegCellW  = 2'd2;
  localparam logic [1:0] RegCellH  = 2'd3;

  // Quotient bits per division chain
  localparam int unsigned SizeBits = 13;
  localparam int unsigned SrcBits  = 14;

  typedef struct packed {
    logic [12:0] cw;
    logic [12:0] ch;
    logic [13:0] pw;
    logic [13:0] ph;
    logic [13:0] aw_full;
    logic [13:0] ah_full;
  } cfg_t;

  typedef struct packed {
    logic [13:0] slot;
    logic [13:0] sw;
    logic [13:0] sh;
    logic [12:0] dx;
    logic [12:0] dy;
    logic        alone;
    logic        shrunk;
    logic        wide;
    logic [26:0] prod_hw;
    logic [26:0] prod_wh;
    logic [13:0] cols_rem;
    logic [12:0] cols_q;
    logic [13:0] rows_rem;
    logic [12:0] rows_q;
    logic [26:0] dsz_rem;
    logic [13:0] dsz_d;
    logic [12:0] dsz_q;
    logic [13:0] dw;
    logic [13:0] dh;
    logic [13:0] sl_rem;
    logic [13:0] sl_q;
    logic [26:0] sx_rem;
    logic [13:0] sx_q;
    logic [26:0] sy_rem;
    logic [13:0] sy_q;
    logic        ok;
    logic [26:0] colx;
    logic [27:0] rowy;
    logic [12:0] ox;
    logic [12:0] oy;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [27:0] rem;
  } step_t;

  // One restoring division step against the divisor shifted to a fixed bit
  function automatic step_t div_step(input logic [27:0] rem, input logic [13:0] dsr,
                                     input logic [3:0] sh);
    logic [27:0] shifted;
    step_t       res;
    shifted = {14'd0, dsr} << sh;
    res.hit = (rem >= shifted);
    res.rem = res.hit ? (rem - shifted) : rem;
    return res;
  endfunction

endpackage

// File: sv/sgsba_in_if.sv
interface sgsba_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] slot;
  logic [13:0] source_width;
  logic [13:0] source_height;
  logic [12:0] draw_x;
  logic [12:0] draw_y;
  logic        alone;

  modport source(output valid, slot, source_width, source_height, draw_x, draw_y, alone,
                 input ready);
  modport sink(input valid, slot, source_width, source_height, draw_x, draw_y, alone,
               output ready);
endinterface

// File: sv/sgsba_out_if.sv
interface sgsba_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] drawn_width;
  logic [13:0] drawn_height;
  logic [12:0] source_x;
  logic [12:0] source_y;
  logic [12:0] atlas_x;
  logic [12:0] atlas_y;
  logic        write_enable;

  modport source(output valid, drawn_width, drawn_height, source_x, source_y, atlas_x,
                 atlas_y, write_enable, input ready);
  modport sink(input valid, drawn_width, drawn_height, source_x, source_y, atlas_x,
               atlas_y, write_enable, output ready);
endinterface

// File: sv/sgsba_cell.sv
module sgsba_cell import sgsba_pkg::*; #(
  parameter bit          PHASE_B = 1'b0,
  parameter int unsigned BIT     = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  localparam logic [3:0] Sh = 4'(BIT);

  logic  valid_q;
  item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  if (PHASE_B) begin : g_src
    step_t st_l, st_x, st_y;
    // Slot split into grid row and column, and both source coordinates
    always_comb begin
      st_l = div_step({14'd0, item_i.sl_rem}, {1'b0, item_i.cols_q}, Sh);
      st_x = div_step({1'b0, item_i.sx_rem}, item_i.dw, Sh);
      st_y = div_step({1'b0, item_i.sy_rem}, item_i.dh, Sh);
      item_d           = item_i;
      item_d.sl_rem    = st_l.rem[13:0];
      item_d.sl_q[BIT] = st_l.hit;
      item_d.sx_rem    = st_x.rem[26:0];
      item_d.sx_q[BIT] = st_x.hit;
      item_d.sy_rem    = st_y.rem[26:0];
      item_d.sy_q[BIT] = st_y.hit;
    end
  end else begin : g_size
    step_t st_c, st_r, st_d;
    // Grid columns, grid rows and the shrunk side
    always_comb begin
      st_c = div_step({14'd0, item_i.cols_rem}, cfg_i.pw, Sh);
      st_r = div_step({14'd0, item_i.rows_rem}, cfg_i.ph, Sh);
      st_d = div_step({1'b0, item_i.dsz_rem}, item_i.dsz_d, Sh);
      item_d             = item_i;
      item_d.cols_rem    = st_c.rem[13:0];
      item_d.cols_q[BIT] = st_c.hit;
      item_d.rows_rem    = st_r.rem[13:0];
      item_d.rows_q[BIT] = st_r.hit;
      item_d.dsz_rem     = st_d.rem[26:0];
      item_d.dsz_q[BIT]  = st_d.hit;
    end
  end

  // Advance when the neighbor takes the item or the cell is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// File: sv/sgsba_chain.sv
module sgsba_chain import sgsba_pkg::*; #(
  parameter bit          PHASE_B = 1'b0,
  parameter int unsigned NCELL   = 13
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  valid_w [NCELL+1];
  logic  ready_w [NCELL+1];
  item_t item_w  [NCELL+1];

  assign valid_w[0]     = valid_i;
  assign item_w[0]      = item_i;
  assign ready_o        = ready_w[0];
  assign valid_o        = valid_w[NCELL];
  assign item_o         = item_w[NCELL];
  assign ready_w[NCELL] = ready_i;

  // Quotient bits from the top down, one per cell
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    sgsba_cell #(
      .PHASE_B(PHASE_B),
      .BIT    (NCELL - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_i),
      .valid_i(valid_w[i]),
      .ready_o(ready_w[i]),
      .item_i (item_w[i]),
      .valid_o(valid_w[i+1]),
      .ready_i(ready_w[i+1]),
      .item_o (item_w[i+1])
    );
  end

endmodule

// File: sv/sprite_grid_scaled_blit_address.sv
// Channel  Direction  Carries
// in_i     sink       slot, source size, draw pixel, alone flag
// out_o    source     drawn size, source pixel, atlas pixel, write enable
// apb      slave      atlas_width, atlas_height, cell_width, cell_height
//
// One item per cycle sustained while the output does not stall.
// Each item passes through two chains of division cells: 13 cells for the grid size and
// shrunk side, 14 cells for the slot split and source coordinates, plus 5 stages.
// Every stage holds its item until the next one takes it, so bubbles fill in.
// Reset clears the valid bits and loads the register reset values.
`include "sprite_grid_scaled_blit_address_defines.svh"

module sprite_grid_scaled_blit_address import sgsba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sgsba_in_if.sink          in_i,
  sgsba_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [13:0] aw_q, ah_q;
  logic [12:0] cw_q, ch_q;
  cfg_t        cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= 14'd1024;
      ah_q <= 14'd1024;
      cw_q <= 13'd64;
      ch_q <= 13'd64;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegAtlasW: aw_q <= pwdata[13:0];
        RegAtlasH: ah_q <= pwdata[13:0];
        RegCellW:  cw_q <= pwdata[12:0];
        RegCellH:  ch_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAtlasW: prdata = {18'd0, aw_q};
      RegAtlasH: prdata = {18'd0, ah_q};
      RegCellW:  prdata = {19'd0, cw_q};
      RegCellH:  prdata = {19'd0, ch_q};
      default:   prdata = '0;
    endcase
  end

  // Padded cell and clamped atlas size
  always_comb begin
    cfg.cw      = cw_q;
    cfg.ch      = ch_q;
    cfg.pw      = {1'b0, cw_q} + 14'(2 * PadPixels);
    cfg.ph      = {1'b0, ch_q} + 14'(2 * PadPixels);
    cfg.aw_full = (17'(aw_q) > 17'(MaxSide)) ? 14'(MaxSide) : aw_q;
    cfg.ah_full = (17'(ah_q) > 17'(MaxSide)) ? 14'(MaxSide) : ah_q;
  end

  // Stage handshakes
  logic  v0_q, v1_q, v2_q, v3_q, v4_q;
  logic  rdy0, rdy1, rdy2, rdy3, rdy4;
  logic  a_ready, a_valid, b_ready, b_valid;
  item_t item0_q, item0_d, item1_q, item1_d, item2_q, item2_d, item3_q, item3_d;
  item_t a_item, b_item;

  assign rdy4       = !v4_q || out_o.ready;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || b_ready;
  assign rdy1       = !v1_q || a_ready;
  assign rdy0       = !v0_q || rdy1;
  assign in_i.ready = rdy0;

  // Capture the item and form the cross products
  always_comb begin
    item0_d         = '0;
    item0_d.slot    = in_i.slot;
    item0_d.sw      = in_i.source_width;
    item0_d.sh      = in_i.source_height;
    item0_d.dx      = in_i.draw_x;
    item0_d.dy      = in_i.draw_y;
    item0_d.alone   = in_i.alone;
    item0_d.prod_hw = {13'd0, in_i.source_height} * {14'd0, cw_q};
    item0_d.prod_wh = {13'd0, in_i.source_width} * {14'd0, ch_q};
  end

  // Pick the shrink side and load the first division chain
  always_comb begin
    item1_d          = item0_q;
    item1_d.shrunk   = (item0_q.sw > {1'b0, cw_q}) || (item0_q.sh > {1'b0, ch_q});
    item1_d.wide     = (item0_q.prod_hw <= item0_q.prod_wh);
    item1_d.dsz_rem  = item1_d.wide ? item0_q.prod_hw : item0_q.prod_wh;
    item1_d.dsz_d    = item1_d.wide ? item0_q.sw : item0_q.sh;
    item1_d.dsz_q    = '0;
    item1_d.cols_rem = cfg.aw_full;
    item1_d.cols_q   = '0;
    item1_d.rows_rem = cfg.ah_full;
    item1_d.rows_q   = '0;
  end

  sgsba_chain #(
    .PHASE_B(1'b0),
    .NCELL  (SizeBits)
  ) u_size_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .valid_i(v1_q),
    .ready_o(a_ready),
    .item_i (item1_q),
    .valid_o(a_valid),
    .ready_i(rdy2),
    .item_o (a_item)
  );

  // Settle the drawn size and load the second division chain
  logic [13:0] dq;
  always_comb begin
    dq      = (a_item.dsz_d == '0) ? 14'd0 : {1'b0, a_item.dsz_q};
    item2_d = a_item;
    if (a_item.shrunk) begin
      item2_d.dw = a_item.wide ? {1'b0, cw_q} : dq;
      item2_d.dh = a_item.wide ? dq : {1'b0, ch_q};
    end else begin
      item2_d.dw = a_item.sw;
      item2_d.dh = a_item.sh;
    end
    item2_d.sl_rem = a_item.slot;
    item2_d.sl_q   = '0;
    item2_d.sx_rem = {14'd0, a_item.dx} * {13'd0, a_item.sw};
    item2_d.sx_q   = '0;
    item2_d.sy_rem = {14'd0, a_item.dy} * {13'd0, a_item.sh};
    item2_d.sy_q   = '0;
  end

  sgsba_chain #(
    .PHASE_B(1'b1),
    .NCELL  (SrcBits)
  ) u_src_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .valid_i(v2_q),
    .ready_o(b_ready),
    .item_i (item2_q),
    .valid_o(b_valid),
    .ready_i(rdy3),
    .item_o (b_item)
  );

  // Cell origin and range checks
  logic [13:0] offx, offy;
  always_comb begin
    offx         = ({1'b0, cw_q} - b_item.dw) >> 1;
    offy         = ({1'b0, ch_q} - b_item.dh) >> 1;
    item3_d      = b_item;
    item3_d.colx = {14'd0, b_item.sl_rem[12:0]} * {13'd0, cfg.pw};
    item3_d.rowy = {14'd0, b_item.sl_q} * {14'd0, cfg.ph};
    item3_d.ox   = offx[12:0];
    item3_d.oy   = offy[12:0];
    item3_d.ok   = (b_item.cols_q != '0) && (b_item.rows_q != '0) &&
                   ({1'b0, b_item.rows_q} > b_item.sl_q) &&
                   ({1'b0, b_item.dx} < b_item.dw) && ({1'b0, b_item.dy} < b_item.dh);
  end

  // Final placement, flip and write decision
  logic [28:0] px, py, aw_cur, ah_cur, ay;
  logic        we;
  always_comb begin
    px     = 29'(item3_q.colx) + 29'(PadPixels) + 29'(item3_q.ox) + 29'(item3_q.dx);
    py     = 29'(item3_q.rowy) + 29'(PadPixels) + 29'(item3_q.oy) + 29'(item3_q.dy);
    aw_cur = 29'(item3_q.alone ? cfg.pw : cfg.aw_full);
    ah_cur = 29'(item3_q.alone ? cfg.ph : cfg.ah_full);
    ay     = ah_cur - 29'd1 - py;
    we     = item3_q.ok && (px < aw_cur) && (py < ah_cur);
  end

  logic [13:0] dw_q, dh_q;
  logic [12:0] sx_q, sy_q, ax_q, ay_q;
  logic        we_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= a_valid;
      if (rdy3) v3_q <= b_valid;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) item0_q <= item0_d;
    if (rdy1) item1_q <= item1_d;
    if (rdy2) item2_q <= item2_d;
    if (rdy3) item3_q <= item3_d;
    if (rdy4) begin
      dw_q <= item3_q.dw;
      dh_q <= item3_q.dh;
      we_q <= we;
      sx_q <= !we ? '0 : (item3_q.shrunk ? item3_q.sx_q[12:0] : item3_q.dx);
      sy_q <= !we ? '0 : (item3_q.shrunk ? item3_q.sy_q[12:0] : item3_q.dy);
      ax_q <= we ? px[12:0] : '0;
      ay_q <= we ? ay[12:0] : '0;
    end
  end

  assign out_o.valid        = v4_q;
  assign out_o.drawn_width  = dw_q;
  assign out_o.drawn_height = dh_q;
  assign out_o.source_x     = sx_q;
  assign out_o.source_y     = sy_q;
  assign out_o.atlas_x      = ax_q;
  assign out_o.atlas_y      = ay_q;
  assign out_o.write_enable = we_q;

  // Input backs up only when every stage is full and the output stalls
  `SGSBA_ASSERT_IMP(a_stall_full, !in_i.ready, out_o.valid && !out_o.ready, "input stalled with room")
  // A written pixel needs a nonempty drawn region
  `SGSBA_ASSERT_IMP(a_we_size, out_o.valid && out_o.write_enable, (out_o.drawn_width != 14'd0) && (out_o.drawn_height != 14'd0), "write with empty region")
  // Skipped pixels carry zero addresses
  `SGSBA_ASSERT_NEVER(a_skip_zero, out_o.valid && !out_o.write_enable && ((out_o.atlas_x != 13'd0) || (out_o.atlas_y != 13'd0) || (out_o.source_x != 13'd0) || (out_o.source_y != 13'd0)), "skipped pixel has address")

endmodule

// File: sim/tb_sprite_grid_scaled_blit_address.sv
module tb_sprite_grid_scaled_blit_address;
  import sgsba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 270;

  typedef struct packed {
    logic [13:0] slot;
    logic [13:0] sw;
    logic [13:0] sh;
    logic [12:0] dx;
    logic [12:0] dy;
    logic        alone;
  } pix_t;

  typedef struct packed {
    logic [13:0] dw;
    logic [13:0] dh;
    logic [12:0] sx;
    logic [12:0] sy;
    logic [12:0] ax;
    logic [12:0] ay;
    logic        we;
  } addr_t;

  typedef struct packed {
    pix_t  pix;
    logic  typed;
    addr_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  sgsba_in_if  in_if();
  sgsba_out_if out_if();

  sprite_grid_scaled_blit_address i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Register copies for prediction
  logic [13:0] atlas_w_q = 14'd1024;
  logic [13:0] atlas_h_q = 14'd1024;
  logic [12:0] cell_w_q  = 13'd64;
  logic [12:0] cell_h_q  = 13'd64;

  addr_t addr_q[$];
  row_t  sent_q[$];
  int    n_fail    = 0;
  int    idle_cnt  = 0;
  bit    calm      = 0;
  logic  in_rdy_n  = 0;

  function automatic longint unsigned safe_div(longint unsigned a, longint unsigned b);
    return (b == 0) ? 0 : a / b;
  endfunction

  // Compute the blit addresses for one destination pixel
  function automatic addr_t blit_addr(pix_t p);
    longint unsigned cw, ch, pw, ph, awf, ahf, cols, rows, dw, dh, aw, ah, px, py;
    longint unsigned sw, sh, dx, dy;
    bit    shrunk;
    addr_t r;
    cw = cell_w_q; ch = cell_h_q;
    sw = p.sw; sh = p.sh; dx = p.dx; dy = p.dy;
    pw = cw + 2 * PadPixels;
    ph = ch + 2 * PadPixels;
    awf = (atlas_w_q > MaxSide) ? MaxSide : atlas_w_q;
    ahf = (atlas_h_q > MaxSide) ? MaxSide : atlas_h_q;
    cols = safe_div(awf, pw);
    rows = safe_div(ahf, ph);
    dw = sw; dh = sh; shrunk = 0;
    if (sw > cw || sh > ch) begin
      shrunk = 1;
      if (cw * sh <= ch * sw) begin
        dw = cw;
        dh = safe_div(sh * cw, sw);
      end else begin
        dh = ch;
        dw = safe_div(sw * ch, sh);
      end
    end
    aw = p.alone ? pw : awf;
    ah = p.alone ? ph : ahf;
    r = '0;
    r.dw = dw[13:0];
    r.dh = dh[13:0];
    if (cols != 0 && rows != 0 && p.slot < cols * rows && dx < dw && dy < dh) begin
      px = (p.slot % cols) * pw + PadPixels + (cw - dw) / 2 + dx;
      py = (p.slot / cols) * ph + PadPixels + (ch - dh) / 2 + dy;
      if (px < aw && py < ah) begin
        r.we = 1;
        r.ax = px[12:0];
        r.ay = 13'(ah - 1 - py);
        r.sx = shrunk ? 13'(safe_div(dx * sw, dw)) : dx[12:0];
        r.sy = shrunk ? 13'(safe_div(dy * sh, dh)) : dy[12:0];
      end
    end
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Latch ready mid-cycle so the sender sees it without a race
  always @(negedge clk_i) in_rdy_n = in_if.ready;

  // Record accepted pixels and their expected addresses
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      row_t  s;
      pix_t  p;
      s = sent_q.pop_front();
      p = '{in_if.slot, in_if.source_width, in_if.source_height,
            in_if.draw_x, in_if.draw_y, in_if.alone};
      addr_q.push_back(s.typed ? s.want : blit_addr(p));
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      addr_t w;
      if (addr_q.size() == 0) begin
        $error("result with no expected item");
        n_fail++;
      end else begin
        w = addr_q.pop_front();
        if (out_if.drawn_width !== w.dw) begin
          $error("drawn_width exp %0d got %0d", w.dw, out_if.drawn_width); n_fail++;
        end
        if (out_if.drawn_height !== w.dh) begin
          $error("drawn_height exp %0d got %0d", w.dh, out_if.drawn_height); n_fail++;
        end
        if (out_if.source_x !== w.sx) begin
          $error("source_x exp %0d got %0d", w.sx, out_if.source_x); n_fail++;
        end
        if (out_if.source_y !== w.sy) begin
          $error("source_y exp %0d got %0d", w.sy, out_if.source_y); n_fail++;
        end
        if (out_if.atlas_x !== w.ax) begin
          $error("atlas_x exp %0d got %0d", w.ax, out_if.atlas_x); n_fail++;
        end
        if (out_if.atlas_y !== w.ay) begin
          $error("atlas_y exp %0d got %0d", w.ay, out_if.atlas_y); n_fail++;
        end
        if (out_if.write_enable !== w.we) begin
          $error("write_enable exp %0d got %0d", w.we, out_if.write_enable); n_fail++;
        end
      end
    end
  end

  // Stall the result side now and then
  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 0;
    else out_if.ready <= calm || ($urandom_range(99) >= 20);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegAtlasW: atlas_w_q = val[13:0];
      RegAtlasH: atlas_h_q = val[13:0];
      RegCellW:  cell_w_q  = val[12:0];
      RegCellH:  cell_h_q  = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int aw, int ah, int cw, int ch);
    reg_write(RegAtlasW, aw);
    reg_write(RegAtlasH, ah);
    reg_write(RegCellW, cw);
    reg_write(RegCellH, ch);
  endtask

  // Hold the pixel until accepted, with an occasional gap first
  task automatic send_pixel(row_t r);
    if (!calm && $urandom_range(99) < 20) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    sent_q.push_back(r);
    in_if.valid         <= 1;
    in_if.slot          <= r.pix.slot;
    in_if.source_width  <= r.pix.sw;
    in_if.source_height <= r.pix.sh;
    in_if.draw_x        <= r.pix.dx;
    in_if.draw_y        <= r.pix.dy;
    in_if.alone         <= r.pix.alone;
    do @(posedge clk_i); while (!in_rdy_n);
  endtask

  // Drop valid right after the last accepted item, then wait for all results
  task automatic drain();
    in_if.valid <= 0;
    while (addr_q.size() != 0 || sent_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random pixel, mostly inside a grid cell and inside the drawn region
  function automatic pix_t rand_pixel();
    pix_t  p;
    addr_t a;
    longint unsigned cw, ch, pw, ph, cap;
    int    k;
    cw = cell_w_q; ch = cell_h_q;
    pw = cw + 2 * PadPixels; ph = ch + 2 * PadPixels;
    cap = safe_div((atlas_w_q > MaxSide) ? MaxSide : atlas_w_q, pw) *
          safe_div((atlas_h_q > MaxSide) ? MaxSide : atlas_h_q, ph);
    k = $urandom_range(99);
    if (k < 5) begin
      p.sw = 14'($urandom); p.sh = 14'($urandom);
    end else if (k < 15) begin
      p.sw = 14'($urandom_range(1, 8192)); p.sh = 14'($urandom_range(1, 8192));
    end else if (k < 55) begin
      p.sw = 14'($urandom_range(1, (cw * 3) / 2 + 1));
      p.sh = 14'($urandom_range(1, (ch * 3) / 2 + 1));
    end else begin
      p.sw = 14'($urandom_range(1, (cw == 0) ? 1 : cw));
      p.sh = 14'($urandom_range(1, (ch == 0) ? 1 : ch));
    end
    p.alone = ($urandom_range(99) < 15);
    if (p.alone) p.slot = ($urandom_range(99) < 80) ? 14'd0 : 14'($urandom);
    else if (cap != 0 && $urandom_range(99) < 80)
      p.slot = 14'($urandom_range(0, (cap > 16384) ? 16383 : cap - 1));
    else p.slot = 14'($urandom);
    p.dx = 0; p.dy = 0;
    a = blit_addr(p);
    if ($urandom_range(99) < 15 || a.dw == 0 || a.dh == 0) begin
      p.dx = 13'($urandom); p.dy = 13'($urandom);
    end else begin
      p.dx = 13'($urandom_range(0, a.dw - 1));
      p.dy = 13'($urandom_range(0, a.dh - 1));
    end
    return p;
  endfunction

  initial begin
    row_t directed[$];
    row_t r;
    int   cfg[6][4];
    directed = '{
      // smallest sprite at the first slot, reset grid
      '{'{14'd0, 14'd1, 14'd1, 13'd0, 13'd0, 1'b0}, 1'b1,
        '{14'd1, 14'd1, 13'd0, 13'd0, 13'd32, 13'd991, 1'b1}},
      // column outside the drawn width
      '{'{14'd0, 14'd1, 14'd1, 13'd1, 13'd0, 1'b0}, 1'b1,
        '{14'd1, 14'd1, 13'd0, 13'd0, 13'd0, 13'd0, 1'b0}},
      // slot beyond grid capacity
      '{'{14'd16383, 14'd64, 14'd64, 13'd0, 13'd0, 1'b0}, 1'b1,
        '{14'd64, 14'd64, 13'd0, 13'd0, 13'd0, 13'd0, 1'b0}},
      // single sprite atlas, last pixel of the cell
      '{'{14'd0, 14'd64, 14'd64, 13'd63, 13'd63, 1'b1}, 1'b1,
        '{14'd64, 14'd64, 13'd63, 13'd63, 13'd64, 13'd1, 1'b1}},
      // wide sprite shrunk to the cell width
      '{'{14'd0, 14'd128, 14'd64, 13'd10, 13'd5, 1'b0}, 1'b1,
        '{14'd64, 14'd32, 13'd20, 13'd10, 13'd11, 13'd1001, 1'b1}},
      '{'{14'd5, 14'd64, 14'd200, 13'd7, 13'd63, 1'b0}, 1'b0, '0},
      '{'{14'd224, 14'd8192, 14'd1, 13'd63, 13'd0, 1'b0}, 1'b0, '0},
      '{'{14'd225, 14'd10, 14'd10, 13'd0, 13'd0, 1'b0}, 1'b0, '0},
      '{'{14'd14, 14'd1, 14'd8192, 13'd0, 13'd63, 1'b0}, 1'b0, '0},
      '{'{14'd16383, 14'd16383, 14'd16383, 13'd8191, 13'd8191, 1'b0}, 1'b0, '0},
      '{'{14'd3, 14'd0, 14'd5, 13'd0, 13'd0, 1'b0}, 1'b0, '0},
      '{'{14'd3, 14'd5, 14'd0, 13'd0, 13'd0, 1'b0}, 1'b0, '0},
      '{'{14'd1, 14'd30, 14'd30, 13'd2, 13'd2, 1'b1}, 1'b0, '0},
      '{'{14'd100, 14'd65, 14'd65, 13'd63, 13'd63, 1'b0}, 1'b0, '0},
      '{'{14'd0, 14'd16383, 14'd1, 13'd8191, 13'd0, 1'b1}, 1'b0, '0}
    };
    cfg = '{'{8192, 8192, 8190, 8190}, '{1, 1, 1, 1}, '{8192, 8192, 1, 1},
            '{300, 200, 17, 9}, '{16383, 16383, 8191, 0}, '{1024, 1024, 64, 64}};

    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_if.valid = 0; in_if.slot = '0; in_if.source_width = '0; in_if.source_height = '0;
    in_if.draw_x = '0; in_if.draw_y = '0; in_if.alone = 0;
    out_if.ready = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // Directed pixels with the reset grid
    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    // Random pixels over several grid settings
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) set_grid(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3]);
      else set_grid($urandom_range(1, 16383), $urandom_range(1, 16383),
                    $urandom_range(1, 200), $urandom_range(1, 200));
      for (int n = 0; n < PhaseItems; n++) begin
        calm = (ph == 2) && (n >= 60) && (n < 200);
        r.pix = rand_pixel();
        r.typed = 0;
        r.want = '0;
        send_pixel(r);
      end
      calm = 0;
      drain();
    end

    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
